// ----- design/dses_pkg.sv -----
package dses_pkg;

  localparam int NUM_W      = 32;
  localparam int SEC_W      = 45;
  localparam int PROD_W     = 48;
  localparam int FP_W       = 3;
  localparam int NUM_FIELDS = 6;

  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic signed [SEC_W-1:0]  sec_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PAREN  = 8'h28;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam num_t K_2        = num_t'(2);
  localparam num_t K_14       = num_t'(14);
  localparam num_t K_367      = num_t'(367);
  localparam num_t K_1461     = num_t'(1461);
  localparam num_t K_3        = num_t'(3);
  localparam num_t K_YEAR0    = num_t'(1900);
  localparam num_t K_4800     = num_t'(4800);
  localparam num_t K_4900     = num_t'(4900);
  localparam num_t K_32075    = num_t'(32075);
  localparam num_t K_EPOCH_JD = num_t'(2440588);

  localparam prod_t SEC_PER_DAY = prod_t'(86400);
  localparam sec_t  SEC_PER_HR  = sec_t'(3600);
  localparam sec_t  SEC_PER_MIN = sec_t'(60);

  // x/12 = (x/4)/3 and x/100 = (x/4)/25 by reciprocal multiply, exact for x/4 below 2^24
  localparam int RCP_IN_W = 24;
  localparam int RCP_W    = 25;
  localparam int SH_BY_3  = 26;
  localparam int SH_BY_25 = 29;
  localparam logic [RCP_W-1:0] RCP_BY_3  = RCP_W'(22369622);  // ceil(2^26 / 3)
  localparam logic [RCP_W-1:0] RCP_BY_25 = RCP_W'(21474837);  // ceil(2^29 / 25)

  typedef enum logic [4:0] {
    ST_DQUOTE,
    ST_SQUOTE,
    ST_PAREN,
    ST_PRE,
    ST_SIGNED,
    ST_INT,
    ST_FRAC,
    ST_DONE,
    ST_A_LD,
    ST_A_DV,
    ST_A_WT,
    ST_B_LD,
    ST_B_DV,
    ST_B_WT,
    ST_C_LD,
    ST_C_MU,
    ST_C_DV,
    ST_C_WT,
    ST_D_LD,
    ST_D_DV,
    ST_D_WT,
    ST_D_DV2,
    ST_D_WT2,
    ST_E0,
    ST_E1,
    ST_OUT
  } dses_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NUM_MA,
    OP_SET_A,
    OP_NUM_B,
    OP_JD_B,
    OP_NUM_C,
    OP_MUL_C,
    OP_JD_C,
    OP_NUM_D,
    OP_MUL_D,
    OP_JD_D,
    OP_SEC_E,
    OP_SEC_F
  } dses_op_t;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_12,
    DIV_BY_100
  } dses_dsel_t;

  typedef struct packed {
    logic       add_digit;
    logic       set_neg;
    logic       set_seen;
    logic       commit;
    logic       load_out;
    logic       div_start;
    dses_dsel_t dsel;
    dses_op_t   op;
  } dses_cmd_t;

  typedef struct packed {
    logic is_dq;
    logic is_sq;
    logic is_paren;
    logic is_blank;
    logic is_minus;
    logic is_plus;
    logic is_digit;
    logic is_dot;
    logic digit_seen;
    logic last_field;
    logic div_done;
    logic out_free;
  } dses_stat_t;

endpackage

// ----- design/dses_div.sv -----
module dses_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  dses_pkg::num_t       dvd,
  input  dses_pkg::dses_dsel_t dsel,
  output logic                 done,
  output dses_pkg::num_t       quo
);

  localparam int SHR_W = dses_pkg::NUM_W - 2;
  localparam int PRD_W = dses_pkg::RCP_IN_W + dses_pkg::RCP_W;

  logic                         stage_r, stage_nxt;
  logic                         done_r, done_nxt;
  logic [SHR_W-1:0]             shr_r, shr_nxt;
  dses_pkg::dses_dsel_t         sel_r, sel_nxt;
  logic                         neg_r, neg_nxt;
  logic [SHR_W-1:0]             quo_r, quo_nxt;
  logic [dses_pkg::NUM_W-1:0]   mag;
  logic [dses_pkg::RCP_W-1:0]   rcp;
  logic [PRD_W-1:0]             prod;
  logic [SHR_W-1:0]             quo_rcp;

  assign mag = dvd[dses_pkg::NUM_W-1] ? dses_pkg::NUM_W'(-dvd) : dses_pkg::NUM_W'(dvd);

  // the start step takes the magnitude and drops the factor of four; the step after it multiplies by the reciprocal
  assign rcp  = (sel_r == dses_pkg::DIV_BY_100) ? dses_pkg::RCP_BY_25 : dses_pkg::RCP_BY_3;
  assign prod = PRD_W'(shr_r[dses_pkg::RCP_IN_W-1:0]) * PRD_W'(rcp);

  always_comb begin
    case (sel_r)
      dses_pkg::DIV_BY_12:  quo_rcp = SHR_W'(prod[PRD_W-1:dses_pkg::SH_BY_3]);
      dses_pkg::DIV_BY_100: quo_rcp = SHR_W'(prod[PRD_W-1:dses_pkg::SH_BY_25]);
      default:              quo_rcp = shr_r;
    endcase
  end

  always_comb begin
    stage_nxt = 1'b0;
    done_nxt  = 1'b0;
    shr_nxt   = shr_r;
    sel_nxt   = sel_r;
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    if (start) begin
      stage_nxt = 1'b1;
      shr_nxt   = mag[dses_pkg::NUM_W-1:2];
      sel_nxt   = dsel;
      neg_nxt   = dvd[dses_pkg::NUM_W-1];
    end else if (stage_r) begin
      quo_nxt  = quo_rcp;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shr_r <= shr_nxt;
    sel_r <= sel_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  // truncate toward zero: quotient takes the sign of the dividend
  assign quo  = neg_r ? -dses_pkg::num_t'(quo_r) : dses_pkg::num_t'(quo_r);
  assign done = done_r;

endmodule

// ----- design/dses_dp.sv -----
module dses_dp #(
  parameter int FIELD_LIMIT = 99999
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [7:0]                      in_char,
  input  dses_pkg::dses_cmd_t             cmd,
  input  logic                            out_tready,
  output dses_pkg::dses_stat_t            stat,
  output logic                            out_valid,
  output logic [dses_pkg::SEC_W-1:0]      out_epoch,
  output logic [dses_pkg::FP_W-1:0]       out_fields
);

  localparam int ACC_W = $clog2(FIELD_LIMIT + 1);
  localparam int FV_W  = ACC_W + 1;
  localparam int MUL_W = ACC_W + 4;

  typedef logic signed [FV_W-1:0] fv_t;

  localparam fv_t FV_START [dses_pkg::NUM_FIELDS] = '{
    fv_t'(0), fv_t'(1), fv_t'(0), fv_t'(0), fv_t'(0), fv_t'(0)
  };

  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic                      seen_r, seen_nxt;
  logic [dses_pkg::FP_W-1:0] idx_r, idx_nxt;
  fv_t                       fv_r   [dses_pkg::NUM_FIELDS];
  fv_t                       fv_nxt [dses_pkg::NUM_FIELDS];
  dses_pkg::num_t            a_r, a_nxt;
  dses_pkg::num_t            num_r, num_nxt;
  dses_pkg::num_t            jd_r, jd_nxt;
  dses_pkg::sec_t            sec_r, sec_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [dses_pkg::SEC_W-1:0] out_epoch_r, out_epoch_nxt;
  logic [dses_pkg::FP_W-1:0] out_fields_r, out_fields_nxt;

  logic [MUL_W-1:0]          acc_sum;
  logic [ACC_W-1:0]          acc_sat;
  fv_t                       mag, v0, v1, v2;
  dses_pkg::num_t            y_w, m_w, d_w;
  dses_pkg::prod_t           day_prod;
  dses_pkg::sec_t            h_s, mi_s, s_s;
  logic                      div_done;
  dses_pkg::num_t            quo;

  dses_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (num_r),
    .dsel  (cmd.dsel),
    .done  (div_done),
    .quo   (quo)
  );

  // character classes
  always_comb begin
    stat.is_dq      = in_char == dses_pkg::CH_DQUOTE;
    stat.is_sq      = in_char == dses_pkg::CH_SQUOTE;
    stat.is_paren   = in_char == dses_pkg::CH_PAREN;
    stat.is_blank   = (in_char == dses_pkg::CH_SPACE) ||
                      ((in_char >= dses_pkg::CH_TAB) && (in_char <= dses_pkg::CH_CR));
    stat.is_minus   = in_char == dses_pkg::CH_MINUS;
    stat.is_plus    = in_char == dses_pkg::CH_PLUS;
    stat.is_digit   = (in_char >= dses_pkg::CH_ZERO) && (in_char <= dses_pkg::CH_NINE);
    stat.is_dot     = in_char == dses_pkg::CH_DOT;
    stat.digit_seen = seen_r;
    stat.last_field = idx_r == dses_pkg::FP_W'(dses_pkg::NUM_FIELDS - 1);
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_tready;
  end

  // digit accumulate with saturation; low nibble of an ASCII digit is its value
  assign acc_sum = MUL_W'(acc_r) * MUL_W'(10) + MUL_W'(in_char[3:0]);
  assign acc_sat = (acc_sum > MUL_W'(FIELD_LIMIT)) ? ACC_W'(FIELD_LIMIT)
                                                    : acc_sum[ACC_W-1:0];

  // signed field value, with the year rule applied to the first field
  assign mag = fv_t'({1'b0, acc_r});
  assign v0  = neg_r ? -mag : mag;
  assign v1  = ((idx_r == '0) && (v0 > fv_t'(1000))) ? v0 - fv_t'(1900) : v0;
  assign v2  = ((idx_r == '0) && (v1 < fv_t'(50)))   ? v1 + fv_t'(100)  : v1;

  assign y_w  = dses_pkg::num_t'(fv_r[0]) + dses_pkg::K_YEAR0;
  assign m_w  = dses_pkg::num_t'(fv_r[1]);
  assign d_w  = dses_pkg::num_t'(fv_r[2]);
  assign h_s  = dses_pkg::sec_t'(fv_r[3]);
  assign mi_s = dses_pkg::sec_t'(fv_r[4]);
  assign s_s  = dses_pkg::sec_t'(fv_r[5]);
  assign day_prod = dses_pkg::prod_t'(jd_r - dses_pkg::K_EPOCH_JD) * dses_pkg::SEC_PER_DAY;

  always_comb begin
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    seen_nxt       = seen_r;
    idx_nxt        = idx_r;
    fv_nxt         = fv_r;
    a_nxt          = a_r;
    num_nxt        = num_r;
    jd_nxt         = jd_r;
    sec_nxt        = sec_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_epoch_nxt  = out_epoch_r;
    out_fields_nxt = out_fields_r;

    if (cmd.add_digit) begin
      acc_nxt  = acc_sat;
      seen_nxt = 1'b1;
    end
    if (cmd.set_seen) seen_nxt = 1'b1;
    if (cmd.set_neg)  neg_nxt  = 1'b1;
    if (cmd.commit) begin
      if (idx_r < dses_pkg::FP_W'(dses_pkg::NUM_FIELDS)) begin
        fv_nxt[idx_r] = v2;
        idx_nxt       = idx_r + dses_pkg::FP_W'(1);
      end
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_epoch_nxt  = sec_r;
      out_fields_nxt = idx_r;
      acc_nxt        = '0;
      neg_nxt        = 1'b0;
      seen_nxt       = 1'b0;
      idx_nxt        = '0;
      fv_nxt         = FV_START;
    end

    unique case (cmd.op)
      dses_pkg::OP_NONE:   ;
      dses_pkg::OP_NUM_MA: num_nxt = m_w - dses_pkg::K_14;
      dses_pkg::OP_SET_A:  a_nxt   = quo;
      dses_pkg::OP_NUM_B:  num_nxt = dses_pkg::K_1461 * (y_w + dses_pkg::K_4800 + a_r);
      dses_pkg::OP_JD_B:   jd_nxt  = quo + d_w - dses_pkg::K_32075;
      dses_pkg::OP_NUM_C:  num_nxt = m_w - dses_pkg::K_2 - ((a_r <<< 3) + (a_r <<< 2));
      dses_pkg::OP_MUL_C:  num_nxt = dses_pkg::K_367 * num_r;
      dses_pkg::OP_JD_C:   jd_nxt  = jd_r + quo;
      dses_pkg::OP_NUM_D:  num_nxt = y_w + dses_pkg::K_4900 + a_r;
      dses_pkg::OP_MUL_D:  num_nxt = dses_pkg::K_3 * quo;
      dses_pkg::OP_JD_D:   jd_nxt  = jd_r - quo;
      dses_pkg::OP_SEC_E:  sec_nxt = dses_pkg::sec_t'(day_prod[dses_pkg::SEC_W-1:0]);
      dses_pkg::OP_SEC_F:  sec_nxt = sec_r + h_s * dses_pkg::SEC_PER_HR
                                     + mi_s * dses_pkg::SEC_PER_MIN + s_s;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      idx_r       <= '0;
      fv_r        <= FV_START;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      seen_r      <= seen_nxt;
      idx_r       <= idx_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    num_r        <= num_nxt;
    jd_r         <= jd_nxt;
    sec_r        <= sec_nxt;
    out_epoch_r  <= out_epoch_nxt;
    out_fields_r <= out_fields_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_epoch  = out_epoch_r;
  assign out_fields = out_fields_r;

endmodule

// ----- design/dses_ctrl.sv -----
module dses_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tlast,
  input  dses_pkg::dses_stat_t stat,
  output logic                 in_tready,
  output dses_pkg::dses_cmd_t  cmd
);

  typedef struct packed {
    dses_pkg::dses_state_t nxt;
    logic                  add_digit;
    logic                  set_neg;
    logic                  set_seen;
    logic                  commit;
  } dec_t;

  dses_pkg::dses_state_t state_r, state_nxt;
  dec_t                  dec;

  // one byte through the parse phases, quote skips falling through in order
  function automatic dec_t decode_byte(dses_pkg::dses_state_t st, dses_pkg::dses_stat_t s);
    dec_t d;
    logic pre;
    logic sgn;
    d.nxt       = st;
    d.add_digit = 1'b0;
    d.set_neg   = 1'b0;
    d.set_seen  = 1'b0;
    d.commit    = 1'b0;
    pre         = 1'b0;
    sgn         = 1'b0;
    unique case (st)
      dses_pkg::ST_DQUOTE: begin
        if (s.is_dq)         d.nxt = dses_pkg::ST_SQUOTE;
        else if (s.is_sq)    d.nxt = dses_pkg::ST_PAREN;
        else if (s.is_paren) d.nxt = dses_pkg::ST_PRE;
        else                 pre   = 1'b1;
      end
      dses_pkg::ST_SQUOTE: begin
        if (s.is_sq)         d.nxt = dses_pkg::ST_PAREN;
        else if (s.is_paren) d.nxt = dses_pkg::ST_PRE;
        else                 pre   = 1'b1;
      end
      dses_pkg::ST_PAREN: begin
        if (s.is_paren) d.nxt = dses_pkg::ST_PRE;
        else            pre   = 1'b1;
      end
      dses_pkg::ST_PRE:    pre = 1'b1;
      dses_pkg::ST_SIGNED: sgn = 1'b1;
      dses_pkg::ST_INT: begin
        if (s.is_digit) d.add_digit = 1'b1;
        else if (s.is_dot) d.nxt = dses_pkg::ST_FRAC;
        else begin
          d.commit = 1'b1;
          d.nxt    = s.last_field ? dses_pkg::ST_DONE : dses_pkg::ST_PRE;
        end
      end
      dses_pkg::ST_FRAC: begin
        if (s.is_digit) d.set_seen = 1'b1;
        else if (s.digit_seen) begin
          d.commit = 1'b1;
          d.nxt    = s.last_field ? dses_pkg::ST_DONE : dses_pkg::ST_PRE;
        end else d.nxt = dses_pkg::ST_DONE;
      end
      default: ;
    endcase
    if (pre) begin
      d.nxt = dses_pkg::ST_PRE;
      if (s.is_blank) d.nxt = dses_pkg::ST_PRE;
      else if (s.is_minus) begin
        d.set_neg = 1'b1;
        d.nxt     = dses_pkg::ST_SIGNED;
      end else if (s.is_plus) d.nxt = dses_pkg::ST_SIGNED;
      else sgn = 1'b1;
    end
    if (sgn) begin
      if (s.is_digit) begin
        d.add_digit = 1'b1;
        d.nxt       = dses_pkg::ST_INT;
      end else if (s.is_dot) d.nxt = dses_pkg::ST_FRAC;
      else d.nxt = dses_pkg::ST_DONE;
    end
    return d;
  endfunction

  assign dec = decode_byte(state_r, stat);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      dses_pkg::ST_DQUOTE, dses_pkg::ST_SQUOTE, dses_pkg::ST_PAREN, dses_pkg::ST_PRE,
      dses_pkg::ST_SIGNED, dses_pkg::ST_INT, dses_pkg::ST_FRAC, dses_pkg::ST_DONE: begin
        if (in_tvalid) state_nxt = in_tlast ? dses_pkg::ST_A_LD : dec.nxt;
      end
      dses_pkg::ST_A_LD:  state_nxt = dses_pkg::ST_A_DV;
      dses_pkg::ST_A_DV:  state_nxt = dses_pkg::ST_A_WT;
      dses_pkg::ST_A_WT:  if (stat.div_done) state_nxt = dses_pkg::ST_B_LD;
      dses_pkg::ST_B_LD:  state_nxt = dses_pkg::ST_B_DV;
      dses_pkg::ST_B_DV:  state_nxt = dses_pkg::ST_B_WT;
      dses_pkg::ST_B_WT:  if (stat.div_done) state_nxt = dses_pkg::ST_C_LD;
      dses_pkg::ST_C_LD:  state_nxt = dses_pkg::ST_C_MU;
      dses_pkg::ST_C_MU:  state_nxt = dses_pkg::ST_C_DV;
      dses_pkg::ST_C_DV:  state_nxt = dses_pkg::ST_C_WT;
      dses_pkg::ST_C_WT:  if (stat.div_done) state_nxt = dses_pkg::ST_D_LD;
      dses_pkg::ST_D_LD:  state_nxt = dses_pkg::ST_D_DV;
      dses_pkg::ST_D_DV:  state_nxt = dses_pkg::ST_D_WT;
      dses_pkg::ST_D_WT:  if (stat.div_done) state_nxt = dses_pkg::ST_D_DV2;
      dses_pkg::ST_D_DV2: state_nxt = dses_pkg::ST_D_WT2;
      dses_pkg::ST_D_WT2: if (stat.div_done) state_nxt = dses_pkg::ST_E0;
      dses_pkg::ST_E0:    state_nxt = dses_pkg::ST_E1;
      dses_pkg::ST_E1:    state_nxt = dses_pkg::ST_OUT;
      dses_pkg::ST_OUT:   if (stat.out_free) state_nxt = dses_pkg::ST_DQUOTE;
      default:            state_nxt = dses_pkg::ST_DQUOTE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    cmd.dsel  = dses_pkg::DIV_BY_4;
    cmd.op    = dses_pkg::OP_NONE;
    unique case (state_r) inside
      dses_pkg::ST_DQUOTE, dses_pkg::ST_SQUOTE, dses_pkg::ST_PAREN, dses_pkg::ST_PRE,
      dses_pkg::ST_SIGNED, dses_pkg::ST_INT, dses_pkg::ST_FRAC, dses_pkg::ST_DONE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tlast) begin
            cmd.commit = ((state_r == dses_pkg::ST_INT) || (state_r == dses_pkg::ST_FRAC))
                         && stat.digit_seen;
          end else begin
            cmd.add_digit = dec.add_digit;
            cmd.set_neg   = dec.set_neg;
            cmd.set_seen  = dec.set_seen;
            cmd.commit    = dec.commit;
          end
        end
      end
      dses_pkg::ST_A_LD: cmd.op = dses_pkg::OP_NUM_MA;
      dses_pkg::ST_A_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = dses_pkg::DIV_BY_12;
      end
      dses_pkg::ST_A_WT: if (stat.div_done) cmd.op = dses_pkg::OP_SET_A;
      dses_pkg::ST_B_LD: cmd.op = dses_pkg::OP_NUM_B;
      dses_pkg::ST_B_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = dses_pkg::DIV_BY_4;
      end
      dses_pkg::ST_B_WT: if (stat.div_done) cmd.op = dses_pkg::OP_JD_B;
      dses_pkg::ST_C_LD: cmd.op = dses_pkg::OP_NUM_C;
      dses_pkg::ST_C_MU: cmd.op = dses_pkg::OP_MUL_C;
      dses_pkg::ST_C_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = dses_pkg::DIV_BY_12;
      end
      dses_pkg::ST_C_WT: if (stat.div_done) cmd.op = dses_pkg::OP_JD_C;
      dses_pkg::ST_D_LD: cmd.op = dses_pkg::OP_NUM_D;
      dses_pkg::ST_D_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = dses_pkg::DIV_BY_100;
      end
      dses_pkg::ST_D_WT: if (stat.div_done) cmd.op = dses_pkg::OP_MUL_D;
      dses_pkg::ST_D_DV2: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = dses_pkg::DIV_BY_4;
      end
      dses_pkg::ST_D_WT2: if (stat.div_done) cmd.op = dses_pkg::OP_JD_D;
      dses_pkg::ST_E0:   cmd.op = dses_pkg::OP_SEC_E;
      dses_pkg::ST_E1:   cmd.op = dses_pkg::OP_SEC_F;
      dses_pkg::ST_OUT:  cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dses_pkg::ST_DQUOTE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/date_string_to_epoch_seconds_top.sv -----
// Date string to Unix seconds. Stream in one byte per beat of a string shaped
// year/month/day,hour:minute:second (leading double quote, single quote and open
// parenthesis skipped once each, in that order); set in_tlast on one extra beat that
// carries no byte to end the string. Each field may have leading whitespace, a sign,
// digits and a fraction that is dropped; magnitudes saturate at FIELD_LIMIT, and
// parsing stops at the first field that is not a number. Years above 1000 lose 1900,
// then years below 50 gain 100; missing fields default to year 1900, month 1, day 0,
// time 00:00:00. The result beat carries the signed 45-bit seconds since 1970-01-01
// and the count of fields parsed. Rate: one byte per cycle while parsing. After the
// end beat in_tready stays low while the day number is formed, mostly in the shared
// constant divider, which takes each of the five divisions of the day formula through
// its steps (take the magnitude and drop the factor of four, do a reciprocal
// multiply, then hand the quotient over). A finished result waits in an output
// register, so the next string streams in while the previous result is still
// unclaimed; a second end beat then holds in the final step until that register drains.
module date_string_to_epoch_seconds_top #(
  parameter int FIELD_LIMIT = 99999
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // string_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [44:0] epoch_seconds, [47:45] fields_parsed
);

  dses_pkg::dses_cmd_t          cmd;
  dses_pkg::dses_stat_t         stat;
  logic [dses_pkg::SEC_W-1:0]   out_epoch;
  logic [dses_pkg::FP_W-1:0]    out_fields;

  // Controller: parse phases per byte, then the day-formula sequence.
  dses_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Datapath: digit accumulator, field store, arithmetic, divider, output register.
  dses_dp #(
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .cmd        (cmd),
    .out_tready (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_epoch  (out_epoch),
    .out_fields (out_fields)
  );

  // Pack the result beat, epoch seconds in the low bits.
  assign out_tdata = {out_fields, out_epoch};

endmodule

// ----- design/dses_checker.sv -----
module dses_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // the end beat starts the computation, which blocks input
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after end of string");

  // at most six fields can be parsed
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] != 3'd7)
    else $error("fields_parsed out of range");

endmodule

bind date_string_to_epoch_seconds_top dses_checker u_dses_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/epoch_scoreboard.sv -----
`timescale 1ns / 1ps
module epoch_scoreboard
  import dses_pkg::*;
#(
  parameter int FIELD_LIMIT = 99999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int unsigned fail_count,
  output int unsigned pending
);

  // Same layout as out_tdata: fields_parsed on top, seconds below.
  typedef struct packed {
    logic [FP_W-1:0] nfields;
    sec_t            secs;
  } stamp_t;

  stamp_t      expected_stamps[$];
  dses_state_t scan_phase;
  logic [2:0]  fields_taken;
  int          field_mag;
  logic        field_neg;
  logic        field_digits;
  int          date_fields[NUM_FIELDS];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s at %0t: got %0d, want %0d", what, $time, got, want);
    fail_count = fail_count + 1;
  endtask

  function automatic void clear_field();
    field_mag    = 0;
    field_neg    = 1'b0;
    field_digits = 1'b0;
  endfunction

  function automatic void clear_date();
    scan_phase   = ST_DQUOTE;
    fields_taken = '0;
    clear_field();
    foreach (date_fields[k]) date_fields[k] = 0;
    date_fields[1] = 1;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    int v;
    v = field_mag * 10 + int'(c - CH_ZERO);
    field_mag    = (v > FIELD_LIMIT) ? FIELD_LIMIT : v;
    field_digits = 1'b1;
  endfunction

  function automatic void close_field();
    int v;
    v = field_neg ? -field_mag : field_mag;
    // year rule: years above 1000 lose 1900, then years below 50 gain 100
    if (fields_taken == 0) begin
      if (v > 1000) v -= 1900;
      if (v < 50) v += 100;
    end
    date_fields[fields_taken] = v;
    fields_taken = fields_taken + 1'b1;
    clear_field();
    scan_phase = (fields_taken >= NUM_FIELDS) ? ST_DONE : ST_PRE;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    // optional quote and parenthesis, each skipped once, in order
    if (scan_phase == ST_DQUOTE) begin
      scan_phase = ST_SQUOTE;
      if (c == CH_DQUOTE) return;
    end
    if (scan_phase == ST_SQUOTE) begin
      scan_phase = ST_PAREN;
      if (c == CH_SQUOTE) return;
    end
    if (scan_phase == ST_PAREN) begin
      scan_phase = ST_PRE;
      if (c == CH_PAREN) return;
    end
    if (scan_phase == ST_PRE) begin
      if (is_blank(c)) return;
      if (c == CH_MINUS) begin
        field_neg  = 1'b1;
        scan_phase = ST_SIGNED;
        return;
      end
      scan_phase = ST_SIGNED;
      if (c == CH_PLUS) return;
    end
    case (scan_phase)
      ST_SIGNED: begin
        if (is_digit(c)) begin
          add_digit(c);
          scan_phase = ST_INT;
        end else if (c == CH_DOT) begin
          scan_phase = ST_FRAC;
        end else begin
          scan_phase = ST_DONE;
        end
      end
      ST_INT: begin
        if (is_digit(c)) add_digit(c);
        else if (c == CH_DOT) scan_phase = ST_FRAC;
        else close_field();
      end
      ST_FRAC: begin
        if (is_digit(c)) field_digits = 1'b1;
        else if (field_digits) close_field();
        else scan_phase = ST_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic stamp_t date_to_epoch();
    longint yr, mo, a, jd, secs;
    stamp_t s;
    if ((scan_phase == ST_INT || scan_phase == ST_FRAC) && field_digits) close_field();
    yr = 1900 + date_fields[0];
    mo = date_fields[1];
    a  = (mo - 14) / 12;
    jd = date_fields[2] - 32075 + 1461 * (yr + 4800 + a) / 4
         + 367 * (mo - 2 - a * 12) / 12 - 3 * ((yr + 4900 + a) / 100) / 4;
    secs = (jd - 2440588) * 86400 + 3600 * date_fields[3] + 60 * date_fields[4]
           + date_fields[5];
    s.secs    = sec_t'(secs);
    s.nfields = fields_taken;
    clear_date();
    return s;
  endfunction

  task automatic check_stamp(stamp_t got);
    stamp_t want;
    if (expected_stamps.size() == 0) begin
      report_mismatch("result with no string ended", longint'(got.secs), 0);
      return;
    end
    want = expected_stamps.pop_front();
    if (got.secs !== want.secs)
      report_mismatch("epoch_seconds", longint'(got.secs), longint'(want.secs));
    if (got.nfields !== want.nfields)
      report_mismatch("fields_parsed", got.nfields, want.nfields);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_date();
      expected_stamps.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_stamp(stamp_t'(out_tdata));
      if (in_tvalid && in_tready) begin
        if (in_tlast) expected_stamps.push_back(date_to_epoch());
        else scan_char(in_tdata);
      end
    end
    pending = expected_stamps.size();
  end

endmodule

// ----- sim/date_string_to_epoch_seconds_top_tb.sv -----
`timescale 1ns / 1ps
module date_string_to_epoch_seconds_top_tb;
  import dses_pkg::*;

  localparam int FIELD_LIMIT  = 99999;
  // The run limit leaves room for the slowest correct run: idle gaps before every beat,
  // about a hundred end beats, receiver stalls and the long hold.
  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_BEATS = 1450;
  // wait well past the day-number pass that follows an end beat
  localparam int END_LATENCY  = 200;
  localparam int LONG_HOLD    = 800;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  // receiver ready before the long hold gate is applied
  logic        sink_ready = 1'b0;
  logic        hold_req   = 1'b0;
  logic        hold_armed = 1'b0;
  int          hold_left  = 0;
  int          cycle_count = 0;
  int          send_idle_max = 10;
  int          recv_idle_max = 10;
  int          beats_sent = 0;
  int unsigned fail_count;
  int unsigned pending;

  // bytes of the string being built, sent one beat each
  logic [7:0]  date_text[$];

  // The long hold gates ready off while hold_left counts down below.
  assign out_tready = sink_ready && (hold_left == 0);

  date_string_to_epoch_seconds_top #(
    .FIELD_LIMIT(FIELD_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  epoch_scoreboard #(
    .FIELD_LIMIT(FIELD_LIMIT)
  ) scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Start the long receiver hold-off once on request, then count it down.
  always @(posedge clk) begin
    if (hold_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left  <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result sink: draw a stall before each beat, then hold ready until a beat moves.
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, recv_idle_max);
      if (gap != 0) begin
        sink_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sink_ready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  function automatic void put_char(logic [7:0] c);
    date_text.push_back(c);
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // Any byte that ends a number: neither a digit nor a dot.
  function automatic logic [7:0] odd_separator();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT);
    return c;
  endfunction

  // One numeric field: optional blanks, sign, integer digits, fraction, separator.
  function automatic void put_field(int idx, logic last);
    int    mag;
    int    k;
    string digits;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_char(blank_char());
    case ($urandom_range(0, 7))
      0:       put_char(CH_MINUS);
      1:       put_char(CH_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0:       mag = $urandom_range(0, 999999);  // drive the magnitude into saturation
      1:       mag = -1;                         // no integer digits at all
      default: begin
        case (idx)
          0: begin
            case ($urandom_range(0, 2))
              0:       mag = $urandom_range(0, 99);
              1:       mag = $urandom_range(100, 1000);
              default: mag = $urandom_range(1001, 2100);
            endcase
          end
          1:       mag = $urandom_range(1, 12);
          2:       mag = $urandom_range(1, 31);
          3:       mag = $urandom_range(0, 23);
          default: mag = $urandom_range(0, 59);
        endcase
      end
    endcase
    if (mag >= 0) begin
      if ($urandom_range(0, 7) == 0) put_char(CH_ZERO);
      digits = $sformatf("%0d", mag);
      for (k = 0; k < digits.len(); k++) put_char(digits[k]);
    end
    // fraction part; with no integer digits this yields a lone dot, a bare
    // fraction, or nothing (lone sign / empty field)
    if ((mag < 0 && $urandom_range(0, 1) == 0) || $urandom_range(0, 5) == 0) begin
      put_char(CH_DOT);
      repeat ($urandom_range(0, 3)) put_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    // the last field may run straight into the end beat
    if (last && $urandom_range(0, 1) == 0) return;
    if ($urandom_range(0, 5) == 0) begin
      put_char(odd_separator());
    end else begin
      case (idx)
        0, 1:    put_char("/");
        2:       put_char(",");
        3, 4:    put_char(":");
        default: put_char(odd_separator());
      endcase
    end
  endfunction

  function automatic void build_date();
    int nf;
    int k;
    if ($urandom_range(0, 15) == 0) begin
      // a lone quote or parenthesis, possibly out of order
      case ($urandom_range(0, 2))
        0:       put_char(CH_DQUOTE);
        1:       put_char(CH_SQUOTE);
        default: put_char(CH_PAREN);
      endcase
    end else begin
      if ($urandom_range(0, 2) == 0) put_char(CH_DQUOTE);
      if ($urandom_range(0, 2) == 0) put_char(CH_SQUOTE);
      if ($urandom_range(0, 2) == 0) put_char(CH_PAREN);
    end
    // mostly full dates so the later fields and the six-field stop get exercised
    nf = ($urandom_range(0, 3) != 0) ? NUM_FIELDS : $urandom_range(0, NUM_FIELDS - 1);
    for (k = 0; k < nf; k++) put_field(k, k == nf - 1);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
  endfunction

  // Junk strings: raw bytes mixed with number-like characters.
  function automatic void build_noise();
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 1) == 0) put_char(8'($urandom_range(0, 255)));
      else put_char(8'($urandom_range(CH_PLUS, CH_NINE)));
    end
  endfunction

  // Offer one beat after a random gap; return at the edge where it is taken.
  task automatic send_beat(logic [7:0] c, logic last);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send the buffered string, then the end beat with a don't-care byte.
  task automatic send_text();
    int k;
    for (k = 0; k < date_text.size(); k++) send_beat(date_text[k], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    beats_sent += date_text.size() + 1;
    date_text.delete();
  endtask

  // Drop valid and hold off until every expected result has come back.
  // Sample the count at the falling edge, away from the scoreboard's update.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic int pick_idle();
    return ($urandom_range(0, 3) == 0) ? 0 : 10;
  endfunction

  initial begin : stimulus
    logic held;
    int   saved_idle;
    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty string: every field stays at its default, year 1900, month 1, day 0, 00:00:00.
    send_text();

    // All three prefixes, minus with a dropped fraction, plus, month out of range,
    // a field that is only a fraction, and a letter as separator.
    put_char(CH_DQUOTE); put_char(CH_SQUOTE); put_char(CH_PAREN);
    put_char(CH_MINUS); put_char("1"); put_char(CH_DOT); put_char("5"); put_char("/");
    put_char(CH_PLUS); put_char("1"); put_char("3"); put_char("/");
    put_char(CH_DOT); put_char("9"); put_char("e");
    send_text();

    // Leading tab, saturating year, then a sign followed by a zero byte stops the
    // parse; the 0xFF after the stop is ignored.
    put_char(CH_TAB);
    repeat (6) put_char("9");
    put_char("/"); put_char(CH_MINUS); put_char(8'h00); put_char(8'hFF);
    send_text();
    drain_results();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      // switch idle style now and then, including stretches with no gaps at all
      if ($urandom_range(0, 7) == 0) begin
        send_idle_max = pick_idle();
        recv_idle_max = pick_idle();
      end
      if (!held && beats_sent > RANDOM_BEATS / 3) begin
        // Hold the result side off and keep streaming so the output register
        // fills and the block backs up onto its input.
        held = 1'b1;
        saved_idle = send_idle_max;
        send_idle_max = 0;
        hold_req <= 1'b1;
        repeat (4) begin
          build_date();
          send_text();
        end
        send_idle_max = saved_idle;
        drain_results();
      end else if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end
      if ($urandom_range(0, 7) == 0) build_noise();
      else build_date();
      send_text();
    end

    drain_results();
    repeat (END_LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
